### hw/rtl/cfd_pkg.sv
package cfd_pkg;

  // Widths of the configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegGapTimeout = 2'd0,
    RegMinLen     = 2'd1,
    RegMaxLen     = 2'd2
  } cfd_reg_e;

  // Meaning of the op field of an input transfer.
  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } cfd_op_e;

  // Register reset values.
  localparam logic [9:0] GapTimeoutRst = 10'd50;
  localparam logic [5:0] MinLenRst     = 6'd6;
  localparam logic [5:0] MaxLenRst     = 6'd32;

  // The idle counter saturates here.
  localparam logic [9:0] IdleMax = 10'h3FF;

  // CRC-16/XMODEM polynomial.
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Acknowledge byte codes.
  localparam logic [7:0] AckHiMask    = 8'hF0;
  localparam logic [7:0] AckLowCode   = 8'h0A;
  localparam logic [7:0] AckAltByte   = 8'h1A;
  localparam logic [7:0] AckAltHeader = 8'h0F;

  // One cell of the byte chain: the byte, the CRC from this byte to the
  // newest one, and whether the frame starting here had a zero CRC.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc;
    logic        ok;
  } cfd_entry_t;

  // Chain control shared by all cells.
  typedef struct packed {
    logic       ins;
    logic       rot;
    logic [7:0] rx_byte;
  } cfd_shift_t;

  // Scan status back to the control.
  typedef struct packed {
    logic       done;
    logic       ack_set;
    logic [7:0] ack_hdr;
  } cfd_scan_sts_t;

  // One byte of CRC-16/XMODEM, MSB first, no reflection.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int unsigned i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // True when b acknowledges a frame whose second byte is hdr.
  function automatic logic is_ack(input logic [7:0] hdr, input logic [7:0] b);
    return (b == ((hdr & AckHiMask) | AckLowCode)) ||
           ((b == AckAltByte) && (hdr == AckAltHeader));
  endfunction

endpackage

### hw/rtl/cfd_if.sv
// Input channel: received bytes and millisecond ticks.
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, op, rx_byte, input ready);
  modport sink (input valid, op, rx_byte, output ready);
endinterface

// Output channel: bytes of validated frames.
interface cfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic [5:0] frame_length;

  modport source (output valid, frame_byte, frame_last, frame_length, input ready);
  modport sink (input valid, frame_byte, frame_last, frame_length, output ready);
endinterface

### hw/rtl/cfd_cell.sv
module cfd_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfd_pkg::cfd_shift_t ctl_i,
  input  cfd_pkg::cfd_entry_t prev_i,
  output cfd_pkg::cfd_entry_t entry_o
);

  // A byte in this cell is IDX bytes older than the newest one, so a frame
  // starting here is complete when its length is IDX + 1.
  localparam logic [8:0] LenHere = 9'(IDX + 1);

  logic [7:0]  data_q;
  logic [15:0] crc_q;
  logic        ok_q, ok_d;
  logic [15:0] crc_upd;
  logic        len_match;

  assign crc_upd   = cfd_pkg::crc16_step(prev_i.crc, ctl_i.rx_byte);
  assign len_match = ((9'(prev_i.data) + 9'd4) == LenHere);

  // The CRC result is latched once, when the candidate frame just fits.
  always_comb begin
    ok_d = ok_q;
    if (ctl_i.ins) begin
      ok_d = len_match ? (crc_upd == 16'h0000) : prev_i.ok;
    end else if (ctl_i.rot) begin
      ok_d = prev_i.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  // Byte and running CRC move along the chain; a new byte extends every CRC.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      data_q <= prev_i.data;
      crc_q  <= crc_upd;
    end else if (ctl_i.rot) begin
      data_q <= prev_i.data;
      crc_q  <= prev_i.crc;
    end
  end

  assign entry_o = '{data: data_q, crc: crc_q, ok: ok_q};

endmodule

### hw/rtl/cfd_scan.sv
module cfd_scan #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  cfd_pkg::cfd_entry_t    tap_i,
  input  logic [$clog2(MAX_FRAME+2)-1:0] fill_i,
  input  logic [5:0]             min_len_i,
  input  logic [5:0]             max_len_i,
  output logic                   rot_o,
  output cfd_pkg::cfd_scan_sts_t sts_o,
  output logic [$clog2(MAX_FRAME+2)-1:0] drop_o,
  cfd_out_if.source              frame_o
);

  localparam int unsigned Depth = MAX_FRAME + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam int unsigned CntW  = $clog2(MAX_FRAME + 1);
  localparam logic [IdxW-1:0] KLast = IdxW'(Depth - 1);

  typedef enum logic [1:0] {
    ModeSeek,
    ModeEmit,
    ModeSkip
  } mode_e;

  mode_e            mode_q, mode_d;
  logic             active_q, active_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic             ackchk_q, ackchk_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [FillW-1:0] last_q, last_d;
  logic             done_q, done_d;
  logic             ack_set_q, ack_set_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             olast_q, olast_d;
  logic [5:0]       olen_q, olen_d;

  logic [FillW:0]   pos_sum;
  logic             present;
  logic [FillW-1:0] pos, pos_next;
  logic [8:0]       tap_len, len_lim;
  logic             cand, cap_hit, ack_skip, frame_end, slot_free;
  logic             emit, e_last, adv;
  logic [5:0]       e_len;

  // The tap sees buffer position k + fill - Depth after k rotations.
  assign pos_sum  = (FillW+1)'(k_q) + (FillW+1)'(fill_i);
  assign present  = active_q && (pos_sum >= (FillW+1)'(Depth));
  assign pos      = FillW'(pos_sum - (FillW+1)'(Depth));
  assign pos_next = pos + FillW'(1);

  // Candidate test at the tap: length within limits and a latched zero CRC.
  assign tap_len   = 9'(tap_i.data) + 9'd4;
  assign len_lim   = (9'(max_len_i) < 9'(MAX_FRAME)) ? 9'(max_len_i) : 9'(MAX_FRAME);
  assign cand      = tap_i.ok && (tap_len >= 9'(min_len_i)) && (tap_len <= len_lim);
  assign cap_hit   = (10'(n_q) + 10'(tap_len)) > 10'(MAX_FRAME);
  assign ack_skip  = ackchk_q && cfd_pkg::is_ack(hdr_q, tap_i.data);
  assign frame_end = ((cnt_q + CntW'(1)) == len_q);
  assign slot_free = !ov_q || frame_o.ready;

  always_comb begin
    emit      = 1'b0;
    e_last    = 1'b0;
    e_len     = 6'(tap_len);
    mode_d    = mode_q;
    active_d  = active_q;
    k_d       = k_q;
    ackchk_d  = ackchk_q;
    hdr_d     = hdr_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    last_d    = last_q;
    ack_set_d = ack_set_q;
    ov_d      = ov_q;
    ob_d      = ob_q;
    olast_d   = olast_q;
    olen_d    = olen_q;

    // Decide what the tap position contributes this cycle.
    if (present) begin
      case (mode_q)
        ModeEmit: begin
          emit   = 1'b1;
          e_last = frame_end;
          e_len  = 6'(len_q);
        end
        ModeSeek: begin
          if (!ack_skip && cand && !cap_hit) begin
            emit = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // The rotation waits while a frame byte cannot be handed over.
    adv = active_q && !(emit && !slot_free);

    if (start_i) begin
      active_d  = 1'b1;
      k_d       = '0;
      mode_d    = ModeSeek;
      ackchk_d  = 1'b0;
      n_d       = '0;
      last_d    = '0;
      ack_set_d = 1'b0;
    end else if (adv) begin
      k_d = k_q + IdxW'(1);
      if (k_q == KLast) begin
        active_d = 1'b0;
      end
      if (present) begin
        case (mode_q)
          ModeEmit: begin
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == CntW'(1)) begin
              hdr_d = tap_i.data;
            end
            if (frame_end) begin
              mode_d   = ModeSeek;
              ackchk_d = 1'b1;
              last_d   = pos_next;
              if (pos_next == fill_i) begin
                ack_set_d = 1'b1;
              end
            end
          end
          ModeSeek: begin
            ackchk_d = 1'b0;
            if (ack_skip) begin
              last_d = pos_next;
            end else if (cand) begin
              if (cap_hit) begin
                mode_d = ModeSkip;
              end else begin
                mode_d = ModeEmit;
                cnt_d  = CntW'(1);
                len_d  = CntW'(tap_len);
                n_d    = n_q + CntW'(tap_len);
              end
            end
          end
          default: begin
            mode_d = mode_q;
          end
        endcase
      end
    end

    done_d = adv && (k_q == KLast);

    // Output register: loads a frame byte or empties on a transfer.
    if (emit && slot_free) begin
      ov_d    = 1'b1;
      ob_d    = tap_i.data;
      olast_d = e_last;
      olen_d  = e_len;
    end else if (frame_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeSeek;
      active_q  <= 1'b0;
      k_q       <= '0;
      ackchk_q  <= 1'b0;
      n_q       <= '0;
      last_q    <= '0;
      done_q    <= 1'b0;
      ack_set_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      active_q  <= active_d;
      k_q       <= k_d;
      ackchk_q  <= ackchk_d;
      n_q       <= n_d;
      last_q    <= last_d;
      done_q    <= done_d;
      ack_set_q <= ack_set_d;
      ov_q      <= ov_d;
    end
  end

  // Frame bookkeeping and output payload.
  always_ff @(posedge clk_i) begin
    hdr_q   <= hdr_d;
    len_q   <= len_d;
    cnt_q   <= cnt_d;
    ob_q    <= ob_d;
    olast_q <= olast_d;
    olen_q  <= olen_d;
  end

  assign rot_o  = adv;
  assign drop_o = last_q;
  assign sts_o  = '{done: done_q, ack_set: ack_set_q, ack_hdr: hdr_q};

  assign frame_o.valid        = ov_q;
  assign frame_o.frame_byte   = ob_q;
  assign frame_o.frame_last   = olast_q;
  assign frame_o.frame_length = olen_q;

endmodule

### hw/rtl/crc_checked_frame_deframer.sv
// Channel   | Dir | Payload                                  | Transfer
// rx_i      | in  | op (byte or ms tick), rx_byte            | valid && ready
// frame_o   | out | frame_byte, frame_last, frame_length     | valid && ready
// cfg_*     | in  | cfg_idx_i selects register, cfg_wdata_i  | cfg_we_i
//
// A tick, like a byte dropped as an acknowledge, leaves the block idle.
// A stored byte is shifted into the cell chain, then the chain rotates once
// through all MAX_FRAME + 1 cells past the scan tap, and then the buffer is
// trimmed.
// A stalled output holds the rotation.
// Reset clears control state and ok flags; bytes and CRCs need no clearing pass.
module crc_checked_frame_deframer #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cfd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cfd_in_if.sink                        rx_i,
  cfd_out_if.source                     frame_o
);

  localparam int unsigned Depth = MAX_FRAME + 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e           state_q, state_d;
  logic [9:0]       gap_timeout_q, gap_timeout_d;
  logic [5:0]       min_len_q, min_len_d;
  logic [5:0]       max_len_q, max_len_d;
  logic [9:0]       idle_q, idle_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             ack_pend_q, ack_pend_d;
  logic [7:0]       ack_hdr_q, ack_hdr_d;

  logic             rx_xfer, is_tick, gap, ack_hit, ins, scan_rot;
  logic [FillW-1:0] fill_base, drop;
  cfd_pkg::cfd_scan_sts_t sts;
  cfd_pkg::cfd_shift_t    shift;
  cfd_pkg::cfd_entry_t    cell_out  [Depth];
  cfd_pkg::cfd_entry_t    cell_prev [Depth];

  assign rx_i.ready = (state_q == StIdle);
  assign rx_xfer    = rx_i.valid && rx_i.ready;
  assign is_tick    = (rx_i.op == cfd_pkg::OpTick);

  // A long idle gap empties the buffer and cancels a pending acknowledge.
  assign gap       = (idle_q > gap_timeout_q);
  assign fill_base = gap ? '0 : fill_q;
  assign ack_hit   = !gap && ack_pend_q && cfd_pkg::is_ack(ack_hdr_q, rx_i.rx_byte);
  assign ins       = rx_xfer && !is_tick && !ack_hit;

  assign shift = '{ins: ins, rot: scan_rot, rx_byte: rx_i.rx_byte};

  // Cell 0 takes the new byte on insert and the far end of the chain on rotation.
  always_comb begin
    if (ins) begin
      cell_prev[0] = '{data: rx_i.rx_byte, crc: 16'h0000, ok: 1'b0};
    end else begin
      cell_prev[0] = cell_out[Depth-1];
    end
    for (int j = 1; j < Depth; j++) begin
      cell_prev[j] = cell_out[j-1];
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    cfd_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (shift),
      .prev_i  (cell_prev[g]),
      .entry_o (cell_out[g])
    );
  end

  cfd_scan #(
    .MAX_FRAME (MAX_FRAME)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ins),
    .tap_i     (cell_out[Depth-1]),
    .fill_i    (fill_q),
    .min_len_i (min_len_q),
    .max_len_i (max_len_q),
    .rot_o     (scan_rot),
    .sts_o     (sts),
    .drop_o    (drop),
    .frame_o   (frame_o)
  );

  // Control: configuration, idle timer, buffer fill and acknowledge tracking.
  always_comb begin
    state_d       = state_q;
    gap_timeout_d = gap_timeout_q;
    min_len_d     = min_len_q;
    max_len_d     = max_len_q;
    idle_d        = idle_q;
    fill_d        = fill_q;
    ack_pend_d    = ack_pend_q;
    ack_hdr_d     = ack_hdr_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        cfd_pkg::RegGapTimeout: gap_timeout_d = cfg_wdata_i[9:0];
        cfd_pkg::RegMinLen:     min_len_d     = cfg_wdata_i[5:0];
        cfd_pkg::RegMaxLen:     max_len_d     = cfg_wdata_i[5:0];
        default:                gap_timeout_d = gap_timeout_q;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (rx_xfer) begin
          if (is_tick) begin
            if (idle_q != cfd_pkg::IdleMax) begin
              idle_d = idle_q + 10'd1;
            end
          end else begin
            idle_d     = '0;
            ack_pend_d = 1'b0;
            if (ack_hit) begin
              fill_d = fill_base;
            end else begin
              fill_d  = fill_base + FillW'(1);
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        if (sts.done) begin
          state_d = StIdle;
          if (drop != '0) begin
            fill_d = fill_q - drop;
          end else if (fill_q > FillW'(MAX_FRAME)) begin
            fill_d = FillW'(MAX_FRAME);
          end
          if (sts.ack_set) begin
            ack_pend_d = 1'b1;
            ack_hdr_d  = sts.ack_hdr;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      gap_timeout_q <= cfd_pkg::GapTimeoutRst;
      min_len_q     <= cfd_pkg::MinLenRst;
      max_len_q     <= cfd_pkg::MaxLenRst;
      idle_q        <= '0;
      fill_q        <= '0;
      ack_pend_q    <= 1'b0;
      ack_hdr_q     <= '0;
    end else begin
      state_q       <= state_d;
      gap_timeout_q <= gap_timeout_d;
      min_len_q     <= min_len_d;
      max_len_q     <= max_len_d;
      idle_q        <= idle_d;
      fill_q        <= fill_d;
      ack_pend_q    <= ack_pend_d;
      ack_hdr_q     <= ack_hdr_d;
    end
  end

endmodule

### hw/rtl/cfd_checker.sv
module cfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_last_i,
  input logic [5:0] out_len_i
);

  logic       in_xfer, out_xfer;
  logic       in_frame_q;
  logic [5:0] len_q;
  logic [5:0] cnt_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Track the frame being delivered: its length and bytes so far.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
      cnt_q      <= '0;
    end else if (out_xfer) begin
      if (out_last_i) begin
        in_frame_q <= 1'b0;
        cnt_q      <= '0;
      end else begin
        in_frame_q <= 1'b1;
        cnt_q      <= cnt_q + 6'd1;
        len_q      <= out_len_i;
      end
    end
  end

  // A waiting frame byte is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("frame byte withdrawn before its transfer");

  // With no frame byte waiting, none appears in the cycle right after an input transfer.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !out_valid_i |=> !out_valid_i)
    else $error("frame byte appeared without a scan");

  // All bytes of one frame carry the same length.
  a_len_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_frame_q |-> out_len_i == len_q)
    else $error("frame length changed inside a frame");

  // The last byte closes a frame of exactly the stated length.
  a_len_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_last_i |-> (cnt_q + 6'd1) == out_len_i)
    else $error("frame byte count does not match frame length");

endmodule

bind crc_checked_frame_deframer cfd_checker u_cfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_i.valid),
  .in_ready_i  (rx_i.ready),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .out_last_i  (frame_o.frame_last),
  .out_len_i   (frame_o.frame_length)
);

### tb/tb_crc_checked_frame_deframer.sv
`timescale 1ns / 1ps

module tb_crc_checked_frame_deframer;

  localparam int unsigned MaxFrame      = 32;
  localparam int unsigned StoreDepth    = MaxFrame + 1;
  localparam int unsigned DrainCycles   = 2 * (MaxFrame + 3) + 16;
  localparam int unsigned WatchdogLimit = 4000;

  // Index with no register behind it; writes to it must have no effect.
  localparam logic [cfd_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  // One pending input transfer.
  typedef struct packed {
    cfd_pkg::cfd_op_e op;
    logic [7:0]       data;
  } rx_item_t;

  // One expected output transfer.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [5:0] len;
  } frame_beat_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [cfd_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cfd_pkg::CfgDataW-1:0] cfg_wdata;

  cfd_in_if  rx_chan ();
  cfd_out_if frame_chan ();

  crc_checked_frame_deframer #(
    .MAX_FRAME(MaxFrame)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_chan),
    .frame_o    (frame_chan)
  );

  // Mirror of the deframer state and its registers.
  logic [7:0]  store_q [StoreDepth];
  int unsigned fill_q;
  int unsigned idle_q;
  bit          ack_wait_q;
  logic [7:0]  ack_hdr_q;
  logic [9:0]  gap_cfg;
  logic [5:0]  min_cfg;
  logic [5:0]  max_cfg;

  rx_item_t    pending_rx[$];
  frame_beat_t expected_beats[$];
  frame_beat_t head_beat;

  int unsigned items_queued = 0;
  int unsigned rx_sent      = 0;
  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_gap       = 0;
  int unsigned out_stall    = 0;
  int unsigned stall_len;
  bit          rx_acc       = 1'b0;
  bit          out_acc      = 1'b0;
  bit          rx_burst     = 1'b0;
  bit          out_burst    = 1'b0;
  logic [7:0]  spare;
  logic [7:0]  tail_byte;
  logic [7:0]  hdr_a;
  logic [7:0]  hdr_b;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // CRC-16/XMODEM, one bit per iteration, MSB first.
  function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] acc, input logic [7:0] din);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ din[k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ cfd_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic bit acks_frame(input logic [7:0] hdr, input logic [7:0] b);
    return (b == ((hdr & cfd_pkg::AckHiMask) | cfd_pkg::AckLowCode)) ||
           ((b == cfd_pkg::AckAltByte) && (hdr == cfd_pkg::AckAltHeader));
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic drop_oldest(input int unsigned n);
    if (n >= fill_q) begin
      fill_q = 0;
    end else begin
      for (int k = 0; k < fill_q - n; k++) begin
        store_q[k] = store_q[k + n];
      end
      fill_q = fill_q - n;
    end
  endtask

  // Predict the frame bytes released by one accepted input transfer.
  task automatic predict_deframe(input logic op, input logic [7:0] b);
    int unsigned eff_max;
    int unsigned pos;
    int unsigned cut;
    int unsigned nres;
    int unsigned len;
    logic [15:0] crc;
    logic [7:0]  hdr;
    frame_beat_t beat;
    if (op == cfd_pkg::OpTick) begin
      if (idle_q < cfd_pkg::IdleMax) begin
        idle_q++;
      end
    end else begin
      // A long silence throws away the partial buffer and any acknowledge test.
      if (idle_q > gap_cfg) begin
        fill_q     = 0;
        ack_wait_q = 1'b0;
      end
      idle_q = 0;
      if (ack_wait_q && acks_frame(ack_hdr_q, b)) begin
        ack_wait_q = 1'b0;
      end else begin
        ack_wait_q = 1'b0;
        if (fill_q >= StoreDepth) begin
          drop_oldest(fill_q - StoreDepth + 1);
        end
        store_q[fill_q] = b;
        fill_q++;

        // Scan each start offset, oldest first, until a frame would pass the output cap.
        eff_max = (max_cfg < MaxFrame) ? max_cfg : MaxFrame;
        pos     = 0;
        cut     = 0;
        nres    = 0;
        while (pos < fill_q) begin
          len = 4 + store_q[pos];
          if (len < min_cfg || len > eff_max || len > fill_q - pos) begin
            pos++;
            continue;
          end
          crc = 16'h0000;
          for (int k = 0; k < len; k++) begin
            crc = crc_xmodem_byte(crc, store_q[pos + k]);
          end
          if (crc != 16'h0000) begin
            pos++;
            continue;
          end
          if (nres + len > MaxFrame) begin
            break;
          end
          for (int k = 0; k < len; k++) begin
            beat.data = store_q[pos + k];
            beat.last = (k + 1 == len);
            beat.len  = 6'(len);
            expected_beats.insert(expected_beats.size(), beat);
          end
          nres += len;
          hdr = store_q[pos + 1];
          pos += len;
          if (pos < fill_q) begin
            if (acks_frame(hdr, store_q[pos])) begin
              pos++;
            end
          end else begin
            ack_wait_q = 1'b1;
            ack_hdr_q  = hdr;
          end
          cut = pos;
        end

        if (cut != 0) begin
          drop_oldest(cut);
        end else if (fill_q > MaxFrame) begin
          drop_oldest(fill_q - MaxFrame);
        end
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_item_t item;
    item.op   = cfd_pkg::OpByte;
    item.data = b;
    pending_rx.insert(pending_rx.size(), item);
    items_queued++;
  endtask

  task automatic queue_tick();
    rx_item_t item;
    item.op   = cfd_pkg::OpTick;
    item.data = 8'($urandom);
    pending_rx.insert(pending_rx.size(), item);
    items_queued++;
  endtask

  // Build a frame with a valid trailing CRC, one bit flipped if corrupt, and
  // queue its first keep bytes, with pause_ticks ticks before byte pause_at.
  // The first unsent byte is handed back in next_byte.
  task automatic queue_frame(input int unsigned len, input logic [7:0] hdr,
                             input bit corrupt, input int unsigned keep,
                             input int unsigned pause_at, input int unsigned pause_ticks,
                             output logic [7:0] next_byte);
    logic [7:0]  fb [MaxFrame];
    logic [15:0] crc;
    int unsigned flip;
    fb[0] = 8'(len - 4);
    fb[1] = hdr;
    for (int k = 2; k < len - 2; k++) begin
      fb[k] = 8'($urandom);
    end
    crc = 16'h0000;
    for (int k = 0; k < len - 2; k++) begin
      crc = crc_xmodem_byte(crc, fb[k]);
    end
    fb[len - 2] = crc[15:8];
    fb[len - 1] = crc[7:0];
    if (corrupt) begin
      flip         = $urandom_range(0, len * 8 - 1);
      fb[flip / 8] = fb[flip / 8] ^ (8'h01 << (flip % 8));
    end
    for (int k = 0; k < keep; k++) begin
      if (k == pause_at) begin
        repeat (pause_ticks) queue_tick();
      end
      queue_byte(fb[k]);
    end
    next_byte = (keep < len) ? fb[keep] : 8'h00;
  endtask

  task automatic queue_ack(input logic [7:0] hdr);
    if (hdr == cfd_pkg::AckAltHeader && $urandom_range(0, 1) == 1) begin
      queue_byte(cfd_pkg::AckAltByte);
    end else begin
      queue_byte((hdr & cfd_pkg::AckHiMask) | cfd_pkg::AckLowCode);
    end
  endtask

  // Mostly well-formed frames sized for the current limits, mixed with
  // broken frames, loose bytes and runs of ticks.
  task automatic queue_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    int unsigned sel;
    int unsigned pause;
    bit          brk;
    logic [7:0]  hdr;
    logic [7:0]  dummy;
    stop_at = items_queued + n_items;
    lo      = (min_cfg < 4) ? 4 : min_cfg;
    hi      = (max_cfg < MaxFrame) ? max_cfg : MaxFrame;
    if (lo > hi) begin
      lo = 4;
      hi = MaxFrame;
    end
    while (items_queued < stop_at) begin
      sel = $urandom_range(0, 99);
      hdr = 8'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        hdr = cfd_pkg::AckAltHeader;
      end
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(lo, hi);
      end else begin
        len = $urandom_range(lo, (lo + 6 < hi) ? lo + 6 : hi);
      end
      if (sel < 60) begin
        pause = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : len;
        queue_frame(len, hdr, 1'b0, len, pause, $urandom_range(1, 3), dummy);
        if ($urandom_range(0, 5) == 0) begin
          queue_tick();
        end
        if ($urandom_range(0, 1) == 1) begin
          queue_ack(hdr);
        end
      end else if (sel < 72) begin
        brk = $urandom_range(0, 1);
        queue_frame(len, hdr, brk, brk ? len : $urandom_range(1, len - 1), len, 0, dummy);
      end else if (sel < 87) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
      end else if (gap_cfg <= 64 && $urandom_range(0, 2) == 0) begin
        // Land right at and just past the timeout.
        repeat (gap_cfg + $urandom_range(0, 2)) queue_tick();
      end else begin
        repeat ($urandom_range(1, 3)) queue_tick();
      end
    end
  endtask

  task automatic write_reg(input logic [cfd_pkg::CfgIdxW-1:0] idx,
                           input logic [cfd_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      cfd_pkg::RegGapTimeout: gap_cfg = value;
      cfd_pkg::RegMinLen:     min_cfg = value[5:0];
      cfd_pkg::RegMaxLen:     max_cfg = value[5:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Unused upper data bits of the length registers carry random values.
  task automatic set_config(input logic [9:0] gap, input logic [5:0] minl,
                            input logic [5:0] maxl);
    write_reg(cfd_pkg::RegGapTimeout, gap);
    write_reg(cfd_pkg::RegMinLen, {4'($urandom), minl});
    write_reg(cfd_pkg::RegMaxLen, {4'($urandom), maxl});
    if ($urandom_range(0, 1) == 1) begin
      write_reg(RegUnused, 10'($urandom));
    end
  endtask

  // Wait until every queued transfer is taken and every frame byte seen,
  // then give the block time to finish a scan that releases nothing.
  task automatic wait_drain();
    while (rx_sent != items_queued || expected_beats.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Drivers: present the next pending transfer once the last one is taken; drive output ready.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) begin
        rx_burst <= ~rx_burst;
      end
      if ($urandom_range(0, 63) == 0) begin
        out_burst <= ~out_burst;
      end
      if (!rx_chan.valid || rx_acc) begin
        if (rx_gap > 0) begin
          rx_chan.valid <= 1'b0;
          rx_gap        <= rx_gap - 1;
        end else if (pending_rx.size() > 0) begin
          rx_chan.valid   <= 1'b1;
          rx_chan.op      <= pending_rx[0].op;
          rx_chan.rx_byte <= pending_rx[0].data;
          void'(pending_rx.pop_front());
          rx_gap <= pick_gap(rx_burst);
        end else begin
          rx_chan.valid <= 1'b0;
        end
      end

      // Output stalls start after a transfer, or now and then while idle.
      if (out_stall > 0) begin
        frame_chan.ready <= 1'b0;
        out_stall        <= out_stall - 1;
      end else begin
        stall_len = (out_acc || $urandom_range(0, 15) == 0) ? pick_gap(out_burst) : 0;
        frame_chan.ready <= (stall_len == 0);
        out_stall        <= (stall_len == 0) ? 0 : stall_len - 1;
      end
    end
  end

  // Monitor: check frame bytes, predict from accepted inputs, watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_acc  <= rx_chan.valid && rx_chan.ready;
      out_acc <= frame_chan.valid && frame_chan.ready;

      if (frame_chan.valid && frame_chan.ready) begin
        if (expected_beats.size() == 0) begin
          $error("frame byte transfer %02h with no expected byte", frame_chan.frame_byte);
          fail_cnt++;
        end else begin
          head_beat = expected_beats.pop_front();
          if (frame_chan.frame_byte !== head_beat.data) begin
            $error("frame_byte: expected %02h, actual %02h",
                   head_beat.data, frame_chan.frame_byte);
            fail_cnt++;
          end
          if (frame_chan.frame_last !== head_beat.last) begin
            $error("frame_last: expected %0d, actual %0d",
                   head_beat.last, frame_chan.frame_last);
            fail_cnt++;
          end
          if (frame_chan.frame_length !== head_beat.len) begin
            $error("frame_length: expected %0d, actual %0d",
                   head_beat.len, frame_chan.frame_length);
            fail_cnt++;
          end
        end
      end

      if (rx_chan.valid && rx_chan.ready) begin
        predict_deframe(rx_chan.op, rx_chan.rx_byte);
        rx_sent++;
      end

      if ((rx_chan.valid && rx_chan.ready) || (frame_chan.valid && frame_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = cfd_pkg::RegGapTimeout;
    cfg_wdata        = '0;
    rx_chan.valid    = 1'b0;
    rx_chan.op       = cfd_pkg::OpByte;
    rx_chan.rx_byte  = 8'h00;
    frame_chan.ready = 1'b0;
    gap_cfg          = cfd_pkg::GapTimeoutRst;
    min_cfg          = cfd_pkg::MinLenRst;
    max_cfg          = cfd_pkg::MaxLenRst;
    fill_q           = 0;
    idle_q           = 0;
    ack_wait_q       = 1'b0;
    ack_hdr_q        = 8'h00;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: alternate and regular acknowledge, field extremes, a tick,
    // and a byte after a frame that is not an acknowledge.
    queue_frame(6, cfd_pkg::AckAltHeader, 1'b0, 6, 6, 0, spare);
    queue_byte(cfd_pkg::AckAltByte);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_tick();
    queue_frame(6, 8'h35, 1'b0, 6, 6, 0, spare);
    queue_byte(8'h3A);
    queue_frame(6, 8'hA5, 1'b0, 6, 6, 0, spare);
    queue_byte(8'h5A);
    queue_random(20);
    wait_drain();

    // Zero timeout: any tick between bytes clears the buffer.
    set_config(10'd0, 6'd4, 6'd32);
    queue_random(20);
    wait_drain();

    // Shortest frames only, with a long pause inside a frame that stays
    // under the largest timeout.
    set_config(10'd1023, 6'd4, 6'd4);
    hdr_a = 8'($urandom);
    queue_frame(4, hdr_a, 1'b0, 4, 2, 20, spare);
    queue_random(15);
    wait_drain();

    // Longest frames only.
    set_config(10'd1023, 6'd32, 6'd32);
    queue_random(20);
    wait_drain();

    // Two short frames sit in the buffer with their acknowledges until the
    // minimum is lowered; the next byte then finds both and skips the
    // buffered acknowledges.
    hdr_a = 8'($urandom);
    hdr_b = 8'($urandom);
    queue_frame(6, hdr_a, 1'b0, 6, 6, 0, spare);
    queue_ack(hdr_a);
    queue_frame(6, hdr_b, 1'b0, 6, 6, 0, spare);
    queue_ack(hdr_b);
    queue_byte(8'($urandom));
    wait_drain();
    set_config(10'd1023, 6'd4, 6'd32);
    queue_byte(8'($urandom));
    wait_drain();

    // A 16-byte and a 17-byte frame complete in the same scan: the second
    // would exceed the per-byte output cap and comes out on the next byte.
    set_config(10'd1023, 6'd17, 6'd32);
    queue_frame(16, 8'($urandom), 1'b0, 16, 16, 0, spare);
    queue_frame(17, 8'($urandom), 1'b0, 16, 17, 0, tail_byte);
    wait_drain();
    set_config(10'd1023, 6'd4, 6'd32);
    queue_byte(tail_byte);
    queue_byte(8'($urandom));
    wait_drain();

    // Limits beyond the supported range.
    set_config(10'($urandom_range(3, 20)), 6'd0, 6'd63);
    queue_random(20);
    wait_drain();

    // Minimum above maximum: nothing is ever accepted.
    set_config(10'd5, 6'd20, 6'd10);
    queue_random(15);
    wait_drain();

    // A couple of ordinary random settings.
    repeat (2) begin
      set_config(10'($urandom_range(1, 30)), 6'($urandom_range(4, 12)),
                 6'($urandom_range(12, 32)));
      queue_random(15);
      wait_drain();
    end

    if (fail_cnt == 0 && expected_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### crc_checked_frame_deframer.f
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_if.sv
hw/rtl/cfd_cell.sv
hw/rtl/cfd_scan.sv
hw/rtl/crc_checked_frame_deframer.sv
hw/rtl/cfd_checker.sv
tb/tb_crc_checked_frame_deframer.sv
